### rtl/lnr_pkg.sv
package lnr_pkg;

  // Field widths fixed by the interface
  localparam int DATA_W = 16;
  localparam int EPS_W  = 16;
  localparam logic [EPS_W-1:0] EPS_RESET = 16'd168;

  // Shared divider width and reciprocal square root format
  localparam int DIV_W     = 64;
  localparam int INV_W     = 32;
  localparam int ISQ_STEPS = 32;

  // The normalised value stays below sqrt(2 * 64) * 2^24, so 30 signed bits hold it
  localparam int NORM_W = 30;

  // Q.24 rounding of the scaled product
  localparam int FRAC_SHIFT = 24;

  // Sequencer states
  typedef enum logic [10:0] {
    ST_LOAD = 11'b000_0000_0001,
    ST_SQ   = 11'b000_0000_0010,
    ST_VAR  = 11'b000_0000_0100,
    ST_RCP  = 11'b000_0000_1000,
    ST_SQRT = 11'b000_0001_0000,
    ST_ORD  = 11'b000_0010_0000,
    ST_OD   = 11'b000_0100_0000,
    ST_OM   = 11'b000_1000_0000,
    ST_OS   = 11'b001_0000_0000,
    ST_ODIV = 11'b010_0000_0000,
    ST_OY   = 11'b100_0000_0000
  } state_t;

endpackage

### rtl/lnr_div.sv
module lnr_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lnr_pkg::DIV_W-1:0]   num,
  input  logic [lnr_pkg::DIV_W-1:0]   den,
  output logic                        done,
  output logic [lnr_pkg::DIV_W-1:0]   quot
);

  localparam int W  = lnr_pkg::DIV_W;
  localparam int CW = $clog2(W);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [W-1:0]  rem_r;
  logic [W-1:0]  num_r;
  logic [W-1:0]  den_r;
  logic [W-1:0]  quot_r;

  logic [W:0]    trial;
  logic          fits;
  logic [W:0]    rem_nxt;

  // One restoring step: bring down the next dividend bit and try the subtraction
  always_comb begin
    trial   = {rem_r, num_r[W-1]};
    fits    = trial >= {1'b0, den_r};
    rem_nxt = fits ? (trial - {1'b0, den_r}) : trial;
  end

  // Control: busy for one step per quotient bit, then a one-cycle done pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      num_r  <= num;
      den_r  <= den;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt[W-1:0];
      num_r  <= {num_r[W-2:0], 1'b0};
      quot_r <= {quot_r[W-2:0], fits};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

### rtl/layer_norm_row.sv
// Loading accepts one item per cycle while in_stall is low; the row buffer is a single-port memory
// of value, gain, bias. After the row end come a sum-of-squares pass, two divisions (variance,
// reciprocal) and a bitwise square root; each result is then read, centred, multiplied and
// divided by 128 * n on the 64-step shared divider before the next starts; output stalls hold
// it back, and input stalls until the row is out. Reset (rst_n low, synchronous) empties the
// row, sets epsilon to 168 and leaves the buffer contents undefined; no clearing pass is needed.
module layer_norm_row #(
  parameter int MAX_FEATURES = 64
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [lnr_pkg::DATA_W-1:0]      in_feature_value,
  input  logic signed [lnr_pkg::DATA_W-1:0]      in_gain,
  input  logic signed [lnr_pkg::DATA_W-1:0]      in_bias,
  input  logic                                   in_row_end,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [lnr_pkg::DATA_W-1:0]      out_normalized_out,
  output logic                                   out_last_out,
  output logic                                   out_clipped,
  output logic                                   out_row_overflow,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [lnr_pkg::EPS_W-1:0]              cfg_epsilon
);

  localparam int DW     = lnr_pkg::DATA_W;
  localparam int CNT_W  = $clog2(MAX_FEATURES + 1);
  localparam int ADDR_W = $clog2(MAX_FEATURES);
  localparam int SUM_W  = DW + CNT_W;
  localparam int D_W    = SUM_W + 1;
  localparam int SQ_W   = 2 * D_W - 1;
  localparam int ACC_W  = SQ_W + CNT_W;
  localparam int P_W    = D_W + lnr_pkg::INV_W + 1;
  localparam int PG_W   = lnr_pkg::NORM_W + DW;
  localparam int RQ_W   = PG_W - lnr_pkg::FRAC_SHIFT;
  localparam int Y_W    = RQ_W + 2;
  localparam int ENT_W  = 3 * DW;
  localparam int DIVW   = lnr_pkg::DIV_W;
  localparam int SQC_W  = $clog2(lnr_pkg::ISQ_STEPS);

  lnr_pkg::state_t state_r, state_nxt;

  logic [lnr_pkg::EPS_W-1:0] eps_r;
  logic [CNT_W-1:0]          fill_r;
  logic                      ovf_r;
  logic signed [SUM_W-1:0]   sum_r;
  logic [CNT_W-1:0]          idx_r;
  logic                      v1_r, v2_r, v3_r;
  logic [ACC_W-1:0]          acc_r;
  logic [2*CNT_W-1:0]        nn_r;
  logic [3*CNT_W-1:0]        n3_r;

  logic [ENT_W-1:0]          mem [MAX_FEATURES];
  logic [ENT_W-1:0]          mem_q_r;
  logic                      mem_re;

  logic signed [D_W-1:0]     d_r;
  logic [SQ_W-1:0]           sq_r;
  logic signed [DW-1:0]      gain_r, bias_r;
  logic signed [P_W-1:0]     prod_r;
  logic signed [lnr_pkg::NORM_W-1:0] norm_r;
  logic [DIVW-1:0]           isq_a_r, isq_rt_r, isq_bit_r;
  logic [SQC_W-1:0]          isq_cnt_r;

  logic                      out_valid_r;
  logic signed [DW-1:0]      out_y_r;
  logic                      out_last_r, out_clip_r, out_ovf_r;

  logic                      in_xfer, out_xfer, room, out_free, last_item;
  logic signed [D_W-1:0]     nx, d_calc;
  logic signed [2*D_W-1:0]   sq_full;
  logic signed [P_W-1:0]     prod_full;
  logic [P_W-1:0]            prod_mag;
  logic signed [PG_W-1:0]    pg_full;
  logic [PG_W-1:0]           pg_mag;
  logic [RQ_W-1:0]           rq;
  logic signed [Y_W-1:0]     rq_s, y;
  logic signed [DW-1:0]      y_sat;
  logic                      y_clip;
  logic [DIVW-1:0]           v_calc, isq_t;
  logic                      isq_ge;
  logic                      div_start, div_done;
  logic [DIVW-1:0]           div_num, div_den, div_quot;

  assign in_stall  = state_r != lnr_pkg::ST_LOAD;
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid_r && !out_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign room      = fill_r < CNT_W'(MAX_FEATURES);
  assign last_item = CNT_W'(idx_r + 1'b1) == fill_r;
  assign cfg_ready = 1'b1;

  // Row buffer: written on load, read one entry a cycle in the SQ pass and once per output item
  assign mem_re = (state_r == lnr_pkg::ST_ORD) ||
                  ((state_r == lnr_pkg::ST_SQ) && (idx_r != fill_r));

  always_ff @(posedge clk) begin
    if (in_xfer && room) begin
      mem[fill_r[ADDR_W-1:0]] <= {in_feature_value, in_gain, in_bias};
    end
    if (mem_re) begin
      mem_q_r <= mem[idx_r[ADDR_W-1:0]];
    end
  end

  // Centred value scaled by n: n * x - sum
  always_comb begin
    nx        = D_W'($signed({1'b0, fill_r})) * D_W'($signed(mem_q_r[ENT_W-1 -: DW]));
    d_calc    = nx - D_W'(sum_r);
    sq_full   = (2*D_W)'(d_r) * (2*D_W)'(d_r);
    prod_full = P_W'(d_r) * P_W'($signed({1'b0, isq_rt_r[lnr_pkg::INV_W-1:0]}));
    prod_mag  = prod_r[P_W-1] ? P_W'(-prod_r) : P_W'(prod_r);
  end

  // Variance plus epsilon, forced to one when zero
  always_comb begin
    v_calc = div_quot + DIVW'(eps_r);
    if (v_calc == '0) begin
      v_calc = DIVW'(1);
    end
  end

  // Square root step
  assign isq_t  = isq_rt_r + isq_bit_r;
  assign isq_ge = isq_a_r >= isq_t;

  // Final scale by gain, round to nearest away from zero, add bias and saturate
  always_comb begin
    pg_full = PG_W'(norm_r) * PG_W'(gain_r);
    pg_mag  = pg_full[PG_W-1] ? PG_W'(-pg_full) : PG_W'(pg_full);
    rq      = RQ_W'((pg_mag + (PG_W'(1) << (lnr_pkg::FRAC_SHIFT - 1))) >>
                    lnr_pkg::FRAC_SHIFT);
    rq_s    = pg_full[PG_W-1] ? -$signed({2'b00, rq}) : $signed({2'b00, rq});
    y       = rq_s + Y_W'(bias_r);
    y_clip  = 1'b1;
    if (y > Y_W'(32767)) begin
      y_sat = 16'sh7fff;
    end else if (y < -Y_W'(32768)) begin
      y_sat = -16'sh8000;
    end else begin
      y_sat  = DW'(y);
      y_clip = 1'b0;
    end
  end

  // Sequencer and divider requests
  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    div_num   = DIVW'(1) << 62;
    div_den   = v_calc;
    case (state_r)
      lnr_pkg::ST_LOAD: begin
        if (in_xfer && in_row_end) begin
          state_nxt = lnr_pkg::ST_SQ;
        end
      end
      lnr_pkg::ST_SQ: begin
        if ((idx_r == fill_r) && !v1_r && !v2_r && !v3_r) begin
          div_start = 1'b1;
          div_num   = DIVW'(acc_r);
          div_den   = DIVW'(n3_r);
          state_nxt = lnr_pkg::ST_VAR;
        end
      end
      lnr_pkg::ST_VAR: begin
        if (div_done) begin
          div_start = 1'b1;
          state_nxt = lnr_pkg::ST_RCP;
        end
      end
      lnr_pkg::ST_RCP: begin
        if (div_done) begin
          state_nxt = lnr_pkg::ST_SQRT;
        end
      end
      lnr_pkg::ST_SQRT: begin
        if (isq_cnt_r == SQC_W'(lnr_pkg::ISQ_STEPS - 1)) begin
          state_nxt = lnr_pkg::ST_ORD;
        end
      end
      lnr_pkg::ST_ORD:  state_nxt = lnr_pkg::ST_OD;
      lnr_pkg::ST_OD:   state_nxt = lnr_pkg::ST_OM;
      lnr_pkg::ST_OM:   state_nxt = lnr_pkg::ST_OS;
      lnr_pkg::ST_OS: begin
        div_start = 1'b1;
        div_num   = (DIVW'(prod_mag) + DIVW'({fill_r, 6'b0})) >> 7;
        div_den   = DIVW'(fill_r);
        state_nxt = lnr_pkg::ST_ODIV;
      end
      lnr_pkg::ST_ODIV: begin
        if (div_done) begin
          state_nxt = lnr_pkg::ST_OY;
        end
      end
      lnr_pkg::ST_OY: begin
        if (out_free) begin
          state_nxt = last_item ? lnr_pkg::ST_LOAD : lnr_pkg::ST_ORD;
        end
      end
      default: state_nxt = lnr_pkg::ST_LOAD;
    endcase
  end

  lnr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lnr_pkg::ST_LOAD;
      eps_r       <= lnr_pkg::EPS_RESET;
      fill_r      <= '0;
      ovf_r       <= 1'b0;
      sum_r       <= '0;
      idx_r       <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      acc_r       <= '0;
      isq_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        eps_r <= cfg_epsilon;
      end

      // Loading: count stored items, keep the running sum, note dropped items
      if (in_xfer) begin
        if (room) begin
          fill_r <= fill_r + 1'b1;
          sum_r  <= sum_r + SUM_W'(in_feature_value);
        end else begin
          ovf_r <= 1'b1;
        end
        idx_r <= '0;
        acc_r <= '0;
      end

      // Sum-of-squares pass pipeline
      v1_r <= (state_r == lnr_pkg::ST_SQ) && mem_re;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if ((state_r == lnr_pkg::ST_SQ) && mem_re) begin
        idx_r <= idx_r + 1'b1;
      end
      if (v3_r) begin
        acc_r <= acc_r + ACC_W'(sq_r);
      end

      // Square root iteration count; the output pass restarts the index
      if (state_r == lnr_pkg::ST_RCP) begin
        isq_cnt_r <= '0;
      end else if (state_r == lnr_pkg::ST_SQRT) begin
        isq_cnt_r <= isq_cnt_r + 1'b1;
        idx_r     <= '0;
      end

      // Output register and end of the row
      if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
      if ((state_r == lnr_pkg::ST_OY) && out_free) begin
        out_valid_r <= 1'b1;
        idx_r       <= idx_r + 1'b1;
        if (last_item) begin
          fill_r <= '0;
          ovf_r  <= 1'b0;
          sum_r  <= '0;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    nn_r <= (2*CNT_W)'(fill_r) * (2*CNT_W)'(fill_r);
    n3_r <= (3*CNT_W)'(nn_r) * (3*CNT_W)'(fill_r);
    if (v1_r || (state_r == lnr_pkg::ST_OD)) begin
      d_r <= d_calc;
    end
    if (state_r == lnr_pkg::ST_OD) begin
      gain_r <= $signed(mem_q_r[2*DW-1 -: DW]);
      bias_r <= $signed(mem_q_r[DW-1:0]);
    end
    sq_r <= sq_full[SQ_W-1:0];
    if (state_r == lnr_pkg::ST_OM) begin
      prod_r <= prod_full;
    end
    if ((state_r == lnr_pkg::ST_ODIV) && div_done) begin
      norm_r <= prod_r[P_W-1] ? -$signed(lnr_pkg::NORM_W'(div_quot))
                              : $signed(lnr_pkg::NORM_W'(div_quot));
    end

    // Bitwise integer square root of 2^62 / v
    if ((state_r == lnr_pkg::ST_RCP) && div_done) begin
      isq_a_r   <= div_quot;
      isq_rt_r  <= '0;
      isq_bit_r <= DIVW'(1) << 62;
    end else if (state_r == lnr_pkg::ST_SQRT) begin
      if (isq_ge) begin
        isq_a_r  <= isq_a_r - isq_t;
        isq_rt_r <= (isq_rt_r >> 1) + isq_bit_r;
      end else begin
        isq_rt_r <= isq_rt_r >> 1;
      end
      isq_bit_r <= isq_bit_r >> 2;
    end

    if ((state_r == lnr_pkg::ST_OY) && out_free) begin
      out_y_r    <= y_sat;
      out_clip_r <= y_clip;
      out_last_r <= last_item;
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_normalized_out = out_y_r;
  assign out_last_out       = out_last_r;
  assign out_clipped        = out_clip_r;
  assign out_row_overflow   = out_ovf_r;

endmodule

### tb/layer_norm_row_tb.sv
module layer_norm_row_tb;

  localparam int NFEAT = 64;

  typedef struct packed {
    logic signed [15:0] value;
    logic signed [15:0] gain;
    logic signed [15:0] bias;
    logic               row_end;
  } feature_t;

  typedef struct packed {
    logic signed [15:0] y;
    logic               last;
    logic               clip;
    logic               ovf;
  } norm_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_feature_value = '0;
  logic signed [15:0] in_gain = '0;
  logic signed [15:0] in_bias = '0;
  logic in_row_end = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_normalized_out;
  logic out_last_out, out_clipped, out_row_overflow;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_epsilon = '0;

  layer_norm_row #(.MAX_FEATURES(NFEAT)) u_dut (.*);

  always #6 clk = ~clk;

  // Predictor state
  logic signed [15:0] row_val[NFEAT], row_gain[NFEAT], row_bias[NFEAT];
  int unsigned row_fill;
  bit          row_dropped;
  logic [15:0] eps_model;

  feature_t     feature_q[$];
  norm_result_t expected_q[$];
  int           mismatches;
  int           send_idle_pct, recv_stall_pct;
  bit           in_taken = 1'b0;

  function automatic logic [63:0] isqrt_u64(logic [63:0] a);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > a) b = b >> 2;
    while (b != 0) begin
      if (a >= r + b) begin
        a = a - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Round to nearest with ties away from zero
  function automatic longint round_div(longint num, longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  // Buffer the feature; on the row end, work out the whole row of results
  task automatic predict_feature(feature_t f);
    longint n, total, d, norm, y;
    logic [63:0] sumsq, mag, varc, v, inv;
    norm_result_t r;
    if (row_fill < NFEAT) begin
      row_val[row_fill] = f.value;
      row_gain[row_fill] = f.gain;
      row_bias[row_fill] = f.bias;
      row_fill++;
    end else begin
      row_dropped = 1'b1;
    end
    if (!f.row_end) return;
    n = row_fill;
    total = 0;
    sumsq = 0;
    for (int i = 0; i < n; i++) total += row_val[i];
    for (int i = 0; i < n; i++) begin
      d = n * row_val[i] - total;
      mag = (d < 0) ? -d : d;
      sumsq += mag * mag;
    end
    varc = sumsq / (n * n * n);
    v = varc + eps_model;
    if (v == 0) v = 1;
    inv = isqrt_u64((64'd1 << 62) / v);
    for (int i = 0; i < n; i++) begin
      d = n * row_val[i] - total;
      norm = round_div(d * longint'(inv), n * 128);
      y = round_div(norm * row_gain[i], longint'(1) << 24) + row_bias[i];
      r.clip = 1'b0;
      if (y > 32767) begin
        y = 32767;
        r.clip = 1'b1;
      end else if (y < -32768) begin
        y = -32768;
        r.clip = 1'b1;
      end
      r.y = y[15:0];
      r.last = (i == n - 1);
      r.ovf = row_dropped;
      expected_q.push_back(r);
    end
    row_fill = 0;
    row_dropped = 1'b0;
  endtask

  // Note whether the presented feature was taken at this rising edge
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && !in_stall;
  end

  // Driver: present the next queued feature at the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        predict_feature(feature_q.pop_front());
      end
      if (!in_valid || in_taken) begin
        if (feature_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_feature_value <= feature_q[0].value;
          in_gain <= feature_q[0].gain;
          in_bias <= feature_q[0].bias;
          in_row_end <= feature_q[0].row_end;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    norm_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result y=%0d", out_normalized_out);
      end else begin
        want = expected_q.pop_front();
        if (want.y !== out_normalized_out || want.last !== out_last_out ||
            want.clip !== out_clipped || want.ovf !== out_row_overflow) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected y=%0d last=%b clip=%b ovf=%b, ",
                      "got y=%0d last=%b clip=%b ovf=%b"},
                     want.y, want.last, want.clip, want.ovf, out_normalized_out,
                     out_last_out, out_clipped, out_row_overflow);
        end
      end
    end
  end

  task automatic add_row(int len, int mode);
    feature_t f;
    for (int i = 0; i < len; i++) begin
      f.value = 16'($urandom);
      f.gain = 16'($urandom);
      f.bias = 16'($urandom);
      if (mode == 1) begin
        f.value = 16'($urandom_range(8191) - 4096);
        f.gain = 16'($urandom_range(8191) - 4096);
        f.bias = 16'($urandom_range(2047) - 1024);
      end
      f.row_end = (i == len - 1);
      feature_q.push_back(f);
    end
  endtask

  // Wait until the driver has handed over everything and all results are back
  task automatic drain();
    while (feature_q.size() != 0 || in_valid) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_epsilon(logic [15:0] e);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_epsilon <= e;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    eps_model = e;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    feature_t f;
    row_fill = 0;
    row_dropped = 1'b0;
    eps_model = lnr_pkg::EPS_RESET;
    mismatches = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows: extremes, single feature, flat row, full-scale swing
    f = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1};
    feature_q.push_back(f);
    f = '{16'sh7fff, 16'sh7fff, -16'sh8000, 1'b0};
    feature_q.push_back(f);
    f = '{-16'sh8000, -16'sh8000, 16'sh7fff, 1'b1};
    feature_q.push_back(f);
    for (int i = 0; i < 4; i++) begin
      f = '{16'sh1000, 16'sh1000, 16'sh0100, i == 3};
      feature_q.push_back(f);
    end
    for (int i = 0; i < 6; i++) begin
      f = '{(i % 2) ? -16'sh8000 : 16'sh7fff, (i < 3) ? 16'sh7fff : -16'sh8000,
            16'sh0000, i == 5};
      feature_q.push_back(f);
    end
    add_row(5, 1);
    drain();

    // Zero epsilon with a flat row exercises the zero-variance floor
    write_epsilon(16'h0000);
    for (int i = 0; i < 3; i++) begin
      f = '{16'sh0123, 16'sh2000, 16'sh0010, i == 2};
      feature_q.push_back(f);
    end
    add_row(4, 0);
    drain();

    // Overrun: 66 items into a 64-entry buffer, then a full-length row
    write_epsilon(16'hffff);
    send_idle_pct = 16;
    recv_stall_pct = 16;
    add_row(66, 1);
    add_row(64, 0);
    drain();

    // Random rows across idling phases and epsilon settings
    for (int ph = 0; ph < 4; ph++) begin
      write_epsilon(ph == 0 ? lnr_pkg::EPS_RESET : 16'($urandom));
      send_idle_pct = (ph == 1 || ph == 3) ? 61 : 0;
      recv_stall_pct = (ph >= 2) ? 61 : 0;
      if (ph == 3) begin
        send_idle_pct = 16;
        recv_stall_pct = 16;
      end
      for (int r = 0; r < 5; r++)
        add_row($urandom_range(1, 6), ($urandom_range(3) != 0) ? 1 : 0);
      drain();
    end

    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("layer_norm_row_tb: PASS");
    end else begin
      $display("layer_norm_row_tb: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #60000000;
    $display("layer_norm_row_tb: FAIL");
    $finish;
  end

endmodule
